### sv/positional_list_with_sort_core_macros.svh
// Assertion helpers shared by the list core.
`ifndef POSITIONAL_LIST_WITH_SORT_CORE_MACROS_SVH
`define POSITIONAL_LIST_WITH_SORT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLWS_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/plws_pkg.sv
`default_nettype none

package plws_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned FUNC_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SORT   = 2'd2,
    FUNC_DUMP   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SORT = 4'b0100,
    ST_DUMP = 4'b1000
  } state_e;

  typedef struct packed {
    logic latch;
    logic apply;
    logic sort_step;
    logic rotate;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic sort_done;
    logic dump_last;
    logic len_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/plws_if.sv
`default_nettype none

interface plws_in_if;
  logic                                valid;
  logic                                ready;
  logic [plws_pkg::FUNC_W-1:0]         func;
  logic [plws_pkg::POS_W-1:0]          position;
  logic signed [plws_pkg::DATA_W-1:0]  value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface plws_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic                                has_value;
  logic signed [plws_pkg::DATA_W-1:0]  entry;
  logic                                last;
  logic [plws_pkg::CNT_W-1:0]          count;

  modport source (output valid, output ok, output has_value, output entry, output last,
                  output count, input ready);
  modport sink   (input valid, input ok, input has_value, input entry, input last,
                  input count, output ready);
endinterface

`default_nettype wire

### sv/plws_ctrl.sv
`default_nettype none

module plws_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [plws_pkg::FUNC_W-1:0] in_func_i,
  output logic                        in_ready_o,
  input  plws_pkg::dp_sts_t           sts_i,
  output plws_pkg::dp_cmd_t           cmd_o
);

  plws_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      plws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (plws_pkg::func_e'(in_func_i))
            plws_pkg::FUNC_INSERT,
            plws_pkg::FUNC_REMOVE: state_d = plws_pkg::ST_EXEC;
            plws_pkg::FUNC_SORT:   state_d = plws_pkg::ST_SORT;
            plws_pkg::FUNC_DUMP:   state_d = plws_pkg::ST_DUMP;
          endcase
        end
      end
      plws_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.apply = 1'b1;
          cmd_o.emit  = 1'b1;
          state_d     = plws_pkg::ST_IDLE;
        end
      end
      plws_pkg::ST_SORT: begin
        if (sts_i.sort_done) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = plws_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.sort_step = 1'b1;
        end
      end
      plws_pkg::ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          // rotate once per word so the list is back in order after the last one
          cmd_o.rotate = !sts_i.len_zero;
          if (sts_i.len_zero || sts_i.dump_last) begin
            state_d = plws_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = plws_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/plws_dp.sv
`default_nettype none

`include "positional_list_with_sort_core_macros.svh"

module plws_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [plws_pkg::FUNC_W-1:0]        in_func_i,
  input  logic [plws_pkg::POS_W-1:0]         in_position_i,
  input  logic signed [plws_pkg::DATA_W-1:0] in_value_i,
  input  plws_pkg::dp_cmd_t                  cmd_i,
  output plws_pkg::dp_sts_t                  sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_ok_o,
  output logic                               out_has_value_o,
  output logic signed [plws_pkg::DATA_W-1:0] out_entry_o,
  output logic                               out_last_o,
  output logic [plws_pkg::CNT_W-1:0]         out_count_o
);

  localparam int unsigned Cap = plws_pkg::CAPACITY;

  // Latched word
  plws_pkg::func_e                    func_q;
  logic [plws_pkg::POS_W-1:0]         pos_q;
  logic signed [plws_pkg::DATA_W-1:0] val_q;

  logic [plws_pkg::CNT_W-1:0] len_q, len_d;
  logic [plws_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic signed [plws_pkg::DATA_W-1:0] ent_q  [Cap];
  logic signed [plws_pkg::DATA_W-1:0] ent_d  [Cap];
  logic signed [plws_pkg::DATA_W-1:0] prev_w [Cap];
  logic signed [plws_pkg::DATA_W-1:0] next_w [Cap];
  logic [Cap-1:0] swp_up;  // entry swaps with the one above it
  logic [Cap-1:0] swp_dn;  // entry swaps with the one below it

  logic out_valid_q, out_valid_d;
  logic out_ok_q, out_has_value_q, out_last_q;
  logic signed [plws_pkg::DATA_W-1:0] out_entry_q;
  logic [plws_pkg::CNT_W-1:0] out_count_q;

  logic exec_ok;
  logic is_insert, is_remove;
  logic out_free;
  logic len_zero, dump_last;

  assign is_insert = (func_q == plws_pkg::FUNC_INSERT);
  assign is_remove = (func_q == plws_pkg::FUNC_REMOVE);
  assign len_zero  = (len_q == '0);
  assign dump_last = (cnt_q == len_q - plws_pkg::CNT_W'(1));
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    exec_ok = 1'b0;
    if (is_insert) begin
      exec_ok = (pos_q <= len_q) && (len_q != plws_pkg::CNT_W'(Cap));
    end else if (is_remove) begin
      exec_ok = (pos_q < len_q);
    end
  end

  assign sts_o.out_free  = out_free;
  assign sts_o.sort_done = (cnt_q == len_q);
  assign sts_o.dump_last = dump_last;
  assign sts_o.len_zero  = len_zero;

  // Neighbor taps and odd-even transposition pairs
  for (genvar i = 0; i < Cap; i++) begin : g_tap
    if (i > 0) begin : g_prev
      assign prev_w[i] = ent_q[i-1];
      assign swp_dn[i] = swp_up[i-1];
    end else begin : g_noprev
      assign prev_w[i] = ent_q[i];
      assign swp_dn[i] = 1'b0;
    end
    if (i < Cap - 1) begin : g_next
      assign next_w[i] = ent_q[i+1];
      assign swp_up[i] = (cnt_q[0] == 1'(i % 2))
                         && (plws_pkg::CNT_W'(i + 1) < len_q)
                         && (ent_q[i] < ent_q[i+1]);
    end else begin : g_nonext
      assign next_w[i] = ent_q[i];
      assign swp_up[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < Cap; i++) begin : g_ent
    localparam logic [plws_pkg::POS_W-1:0] Idx = plws_pkg::POS_W'(i);
    always_comb begin
      ent_d[i] = ent_q[i];
      priority if (cmd_i.apply && exec_ok && is_insert) begin
        if (Idx == pos_q) begin
          ent_d[i] = val_q;
        end else if (Idx > pos_q) begin
          ent_d[i] = prev_w[i];
        end
      end else if (cmd_i.apply && exec_ok && is_remove) begin
        if (Idx >= pos_q) begin
          ent_d[i] = next_w[i];
        end
      end else if (cmd_i.sort_step) begin
        if (swp_up[i]) begin
          ent_d[i] = next_w[i];
        end else if (swp_dn[i]) begin
          ent_d[i] = prev_w[i];
        end
      end else if (cmd_i.rotate) begin
        // head wraps to the tail of the list
        if (Idx == len_q - plws_pkg::CNT_W'(1)) begin
          ent_d[i] = ent_q[0];
        end else begin
          ent_d[i] = next_w[i];
        end
      end else begin
        ent_d[i] = ent_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.apply && exec_ok) begin
      if (is_insert) begin
        len_d = len_q + plws_pkg::CNT_W'(1);
      end else begin
        len_d = len_q - plws_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.latch) begin
      cnt_d = '0;
    end else if (cmd_i.sort_step || cmd_i.rotate) begin
      cnt_d = cnt_q + plws_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= plws_pkg::func_e'(in_func_i);
      pos_q  <= in_position_i;
      val_q  <= in_value_i;
    end
    if (cmd_i.emit) begin
      out_count_q <= len_d;
      unique case (func_q)
        plws_pkg::FUNC_INSERT,
        plws_pkg::FUNC_REMOVE: begin
          out_ok_q        <= exec_ok;
          out_has_value_q <= 1'b0;
          out_entry_q     <= '0;
          out_last_q      <= 1'b1;
        end
        plws_pkg::FUNC_SORT: begin
          out_ok_q        <= 1'b1;
          out_has_value_q <= 1'b0;
          out_entry_q     <= '0;
          out_last_q      <= 1'b1;
        end
        plws_pkg::FUNC_DUMP: begin
          out_ok_q        <= 1'b1;
          out_has_value_q <= !len_zero;
          out_entry_q     <= len_zero ? '0 : ent_q[0];
          out_last_q      <= len_zero || dump_last;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_ok_o        = out_ok_q;
  assign out_has_value_o = out_has_value_q;
  assign out_entry_o     = out_entry_q;
  assign out_last_o      = out_last_q;
  assign out_count_o     = out_count_q;

  `PLWS_ASSERT(a_len_cap, clk_i, rst_ni, 1'b1, len_q <= plws_pkg::CNT_W'(Cap),
               "length over capacity")
  `PLWS_ASSERT(a_cnt_len, clk_i, rst_ni, 1'b1, cnt_q <= len_q, "step counter past length")
  `PLWS_ASSERT_NXT(a_fail_hold, clk_i, rst_ni, cmd_i.apply && !exec_ok, $stable(len_q),
                   "failed op changed length")
  `PLWS_ASSERT(a_emit_free, clk_i, rst_ni, cmd_i.emit, out_free,
               "result overwrites pending word")

endmodule

`default_nettype wire

### sv/positional_list_with_sort_core.sv
// Ordered list of up to 64 signed 32-bit entries with insert-at-index, remove-at-index,
// descending sort and dump. One word is taken at a time. Insert and remove shift the
// entries from the index on in parallel. Sort runs one odd-even compare-and-swap pass
// per cycle across parallel comparators, length passes in all. Dump rotates the entry
// registers by one place per word and sends one word per cycle while the output register
// is free, length words (one word for an empty list). A new word is taken once the
// controller is back in idle, which it enters as the previous operation's final result
// is loaded into the output register, even while that result still waits to be taken.
`default_nettype none

module positional_list_with_sort_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  plws_in_if.sink     req_i,
  plws_out_if.source  rsp_o
);

  plws_pkg::dp_cmd_t cmd;
  plws_pkg::dp_sts_t sts;

  plws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_func_i  (req_i.func),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plws_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_func_i       (req_i.func),
    .in_position_i   (req_i.position),
    .in_value_i      (req_i.value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_ok_o        (rsp_o.ok),
    .out_has_value_o (rsp_o.has_value),
    .out_entry_o     (rsp_o.entry),
    .out_last_o      (rsp_o.last),
    .out_count_o     (rsp_o.count)
  );

endmodule

`default_nettype wire

### test/tb_positional_list_with_sort_core.sv
module tb_positional_list_with_sort_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_TAIL = 30;
  localparam int HOLD_AT    = 40;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    plws_pkg::func_e                     func;
    logic [plws_pkg::POS_W-1:0]          position;
    logic signed [plws_pkg::DATA_W-1:0]  value;
    bit                                  after_drain;
  } list_req_t;

  typedef struct {
    logic                                ok;
    logic                                has_value;
    logic signed [plws_pkg::DATA_W-1:0]  entry;
    logic                                last;
    logic [plws_pkg::CNT_W-1:0]          count;
  } list_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  plws_in_if  req_if ();
  plws_out_if rsp_if ();

  positional_list_with_sort_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5ns clk_i = ~clk_i;

  list_req_t                          pending_reqs[$];
  list_word_t                         due_words[$];
  logic signed [plws_pkg::DATA_W-1:0] shadow_list[plws_pkg::CAPACITY];
  int                                 shadow_len;
  int                                 gen_len;
  int                                 item_total;
  int                                 items_taken;
  int                                 words_owed;
  int                                 words_done;
  int                                 mismatches;
  int                                 gap_left;
  int                                 stall_left;
  int                                 hold_left;
  bit                                 hold_done;
  logic                               hold_on;
  list_req_t                          cur_req;
  logic                               calm;

  assign calm = (item_total > 0) && (items_taken >= item_total - QUIET_TAIL);

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Apply one operation to the shadow list and queue the words it must produce.
  function automatic void predict_list_op(list_req_t r);
    list_word_t                         w;
    logic signed [plws_pkg::DATA_W-1:0] t;
    int                                 pos;
    int                                 i;
    int                                 pass;
    pos = r.position;
    w.ok = 1'b1;
    w.has_value = 1'b0;
    w.entry = '0;
    w.last = 1'b1;
    case (r.func)
      plws_pkg::FUNC_INSERT: begin
        w.ok = (pos <= shadow_len) && (shadow_len < plws_pkg::CAPACITY);
        if (w.ok) begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = r.value;
          shadow_len++;
        end
      end
      plws_pkg::FUNC_REMOVE: begin
        w.ok = pos < shadow_len;
        if (w.ok) begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      plws_pkg::FUNC_SORT: begin
        for (pass = 0; pass < shadow_len; pass++) begin
          for (i = 0; i + 1 < shadow_len; i++) begin
            if (shadow_list[i] < shadow_list[i+1]) begin
              t = shadow_list[i];
              shadow_list[i] = shadow_list[i+1];
              shadow_list[i+1] = t;
            end
          end
        end
      end
      default: begin
      end
    endcase
    w.count = plws_pkg::CNT_W'(shadow_len);
    if (r.func == plws_pkg::FUNC_DUMP && shadow_len > 0) begin
      for (i = 0; i < shadow_len; i++) begin
        w.has_value = 1'b1;
        w.entry = shadow_list[i];
        w.last = (i + 1 == shadow_len);
        due_words.push_back(w);
        words_owed++;
      end
    end else begin
      due_words.push_back(w);
      words_owed++;
    end
  endfunction

  // Queue a request and track the list length the block will see.
  function automatic void add_req(plws_pkg::func_e f, int pos,
                                  logic signed [plws_pkg::DATA_W-1:0] v,
                                  bit drain = 1'b0);
    list_req_t r;
    r.func = f;
    r.position = plws_pkg::POS_W'(pos);
    r.value = v;
    r.after_drain = drain;
    pending_reqs.push_back(r);
    if (f == plws_pkg::FUNC_INSERT && pos <= gen_len && gen_len < plws_pkg::CAPACITY)
      gen_len++;
    if (f == plws_pkg::FUNC_REMOVE && pos < gen_len) gen_len--;
  endfunction

  function automatic logic signed [plws_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic void add_random_req(int insert_w, int remove_w);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < insert_w && gen_len < plws_pkg::CAPACITY) begin
      add_req(plws_pkg::FUNC_INSERT, $urandom_range(0, gen_len), pick_value());
    end else if (sel < insert_w + remove_w && gen_len > 0) begin
      add_req(plws_pkg::FUNC_REMOVE, $urandom_range(0, gen_len - 1), $signed($urandom));
    end else if (sel < 17) begin
      // out-of-range index, list left as it is
      if ($urandom_range(0, 1) == 0)
        add_req(plws_pkg::FUNC_INSERT, $urandom_range(gen_len + 1, 127), pick_value());
      else
        add_req(plws_pkg::FUNC_REMOVE, $urandom_range(gen_len, 127), $signed($urandom));
    end else if (sel < 18) begin
      add_req(plws_pkg::FUNC_SORT, $urandom_range(0, 127), $signed($urandom));
    end else begin
      add_req(plws_pkg::FUNC_DUMP, $urandom_range(0, 127), $signed($urandom));
    end
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic offer;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.func     <= plws_pkg::FUNC_INSERT;
      req_if.position <= '0;
      req_if.value    <= '0;
      items_taken     <= 0;
      gap_left = 0;
      words_owed = 0;
      shadow_len = 0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predict_list_op(cur_req);
        items_taken <= items_taken + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].after_drain || words_done == words_owed)) begin
          cur_req = pending_reqs.pop_front();
          req_if.func     <= cur_req.func;
          req_if.position <= cur_req.position;
          req_if.value    <= cur_req.value;
          offer = 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
        end
      end
      req_if.valid <= offer;
    end
  end

  // Long receiver hold-off: let the block fill up and stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_on <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_left == 0 && !hold_done && items_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      hold_on <= (hold_left != 0);
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    list_word_t w;
    logic       busy;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      words_done   <= 0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_done <= words_done + 1;
        if (due_words.size() == 0) begin
          flag_mismatch("word received with nothing due");
        end else begin
          w = due_words.pop_front();
          if (rsp_if.ok !== w.ok)
            flag_mismatch($sformatf("ok %b, want %b", rsp_if.ok, w.ok));
          if (rsp_if.has_value !== w.has_value)
            flag_mismatch($sformatf("has_value %b, want %b", rsp_if.has_value, w.has_value));
          if (rsp_if.entry !== w.entry)
            flag_mismatch($sformatf("entry %0d, want %0d", rsp_if.entry, w.entry));
          if (rsp_if.last !== w.last)
            flag_mismatch($sformatf("last %b, want %b", rsp_if.last, w.last));
          if (rsp_if.count !== w.count)
            flag_mismatch($sformatf("count %0d, want %0d", rsp_if.count, w.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        busy = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        busy = 1'b1;
      end else begin
        busy = 1'b0;
      end
      rsp_if.ready <= !(busy || hold_on);
    end
  end

  initial begin
    int n;
    rst_ni <= 1'b0;
    mismatches = 0;
    item_total = 0;
    gen_len = 0;

    // empty list corners
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0);
    add_req(plws_pkg::FUNC_SORT, 127, -32'sd1);
    add_req(plws_pkg::FUNC_REMOVE, 0, 32'sd0);
    add_req(plws_pkg::FUNC_INSERT, 1, 32'sd7);
    add_req(plws_pkg::FUNC_INSERT, 0, 32'sh8000_0000);
    add_req(plws_pkg::FUNC_SORT, 0, 32'sd0);
    add_req(plws_pkg::FUNC_DUMP, 127, 32'sh7fff_ffff);
    add_req(plws_pkg::FUNC_INSERT, 1, 32'sh7fff_ffff);
    add_req(plws_pkg::FUNC_INSERT, 0, 32'sd0);
    add_req(plws_pkg::FUNC_INSERT, 1, -32'sd1);
    add_req(plws_pkg::FUNC_INSERT, 127, 32'sd3);
    add_req(plws_pkg::FUNC_REMOVE, 4, -32'sd1);
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0);
    add_req(plws_pkg::FUNC_SORT, 0, 32'sd0);
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0);
    add_req(plws_pkg::FUNC_REMOVE, 3, 32'sd0);
    add_req(plws_pkg::FUNC_REMOVE, 0, 32'sd0);
    add_req(plws_pkg::FUNC_INSERT, 1, 32'sd5);
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0, 1'b1);

    // grow the list to capacity with mostly valid inserts
    n = 0;
    while (gen_len < plws_pkg::CAPACITY) begin
      add_random_req(16, 1);
      n++;
      if (n == 30) pending_reqs[$].after_drain = 1'b1;
    end

    // full list corners
    add_req(plws_pkg::FUNC_INSERT, $urandom_range(0, plws_pkg::CAPACITY), pick_value(), 1'b1);
    add_req(plws_pkg::FUNC_INSERT, 127, pick_value());
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0);
    add_req(plws_pkg::FUNC_SORT, 0, 32'sd0);
    add_req(plws_pkg::FUNC_DUMP, 0, 32'sd0);
    add_req(plws_pkg::FUNC_REMOVE, plws_pkg::CAPACITY, 32'sd0);
    add_req(plws_pkg::FUNC_REMOVE, plws_pkg::CAPACITY - 1, 32'sd0);

    // mixed traffic, leaning to removes
    for (int k = 0; k < 65; k++) begin
      add_random_req(6, 7);
      if (k == 20) pending_reqs[$].after_drain = 1'b1;
    end

    item_total = pending_reqs.size();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == item_total && words_done == words_owed);
    repeat (150) @(posedge clk_i);
    if (due_words.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", due_words.size()));
    if (mismatches == 0) begin
      $display("positional_list_with_sort_core verification clean");
    end else begin
      $display("positional_list_with_sort_core verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("positional_list_with_sort_core verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/plws_pkg.sv
sv/plws_if.sv
sv/plws_ctrl.sv
sv/plws_dp.sv
sv/positional_list_with_sort_core.sv
test/tb_positional_list_with_sort_core.sv
